>>> rtl/sii_pkg.sv
`default_nettype none
package sii_pkg;

   // Field widths of one item.
   localparam int VALUE_BITS = 31;
   localparam int STEP_BITS  = 16;
   localparam int LCM_BITS   = 2 * STEP_BITS;
   localparam int COEF_BITS  = STEP_BITS + 2;

   // The shared divider is wide enough for x0, the aligned low member and the lcm.
   localparam int DIV_BITS = ((VALUE_BITS > LCM_BITS + 1) ? VALUE_BITS : (LCM_BITS + 1)) + 2;
   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   // Datapath operations, one per divide pass.
   typedef logic [3:0] op_type;
   localparam op_type OP_EUC  = 4'd0;
   localparam op_type OP_S1G  = 4'd1;
   localparam op_type OP_S2G  = 4'd2;
   localparam op_type OP_DIFF = 4'd3;
   localparam op_type OP_DG   = 4'd4;
   localparam op_type OP_KMOD = 4'd5;
   localparam op_type OP_X0   = 4'd6;
   localparam op_type OP_T    = 4'd7;
   localparam op_type OP_HI   = 4'd8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic   load;
      logic   go;
      logic   take;
      op_type op;
      logic   emit;
      logic   empty;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_empty;
      logic div_done;
      logic rem_zero;
      logic m_le1;
      logic x_gt_end;
      logic end_inf;
      logic rsp_busy;
   } stat_type;

endpackage
`default_nettype wire

>>> rtl/sii_div.sv
`default_nettype none
module sii_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic                         narrow,
   input  logic [sii_pkg::DIV_BITS-1:0] num,
   input  logic [sii_pkg::DIV_BITS-1:0] den,
   output logic [sii_pkg::DIV_BITS-1:0] quo,
   output logic [sii_pkg::DIV_BITS-1:0] rem,
   output logic                         done
);
   import sii_pkg::*;

   logic [DIV_BITS-1:0] quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [DIV_BITS:0]   shifted, diff;

   // One quotient bit a cycle, restoring form.
   assign shifted = {rem_ff, quo_ff[DIV_BITS-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         // A narrow operand is left aligned so that only its own bits are iterated.
         quo_in  = narrow ? (num << (DIV_BITS - STEP_BITS)) : num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = narrow ? CNT_BITS'(STEP_BITS) : CNT_BITS'(DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIV_BITS]) begin
            rem_in = diff[DIV_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo  = quo_ff;
   assign rem  = rem_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

>>> rtl/sii_datapath.sv
`default_nettype none
module sii_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  sii_pkg::cmd_type               cmd,
   output sii_pkg::stat_type              stat,
   input  logic [sii_pkg::VALUE_BITS-1:0] first_lo,
   input  logic [sii_pkg::STEP_BITS-1:0]  first_step,
   input  logic [sii_pkg::VALUE_BITS-1:0] first_hi,
   input  logic                           first_empty,
   input  logic [sii_pkg::VALUE_BITS-1:0] second_lo,
   input  logic [sii_pkg::STEP_BITS-1:0]  second_step,
   input  logic [sii_pkg::VALUE_BITS-1:0] second_hi,
   input  logic                           second_empty,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sii_pkg::VALUE_BITS:0]   out_lo,
   output logic [sii_pkg::LCM_BITS:0]     out_step,
   output logic [sii_pkg::VALUE_BITS:0]   out_hi,
   output logic                           out_empty
);
   import sii_pkg::*;

   logic [VALUE_BITS-1:0]      lo1_ff, lo1_in, lo2_ff, lo2_in, hi1_ff, hi1_in, hi2_ff, hi2_in;
   logic [STEP_BITS-1:0]       s1_ff, s1_in, s2_ff, s2_in;
   logic                       e_ff, e_in;
   logic [STEP_BITS-1:0]       r0_ff, r0_in, r1_ff, r1_in;
   logic signed [COEF_BITS-1:0] t0_ff, t0_in, t1_ff, t1_in;
   logic [STEP_BITS-1:0]       a_ff, a_in, m_ff, m_in, d_ff, d_in, dq_ff, dq_in, k_ff, k_in;
   logic [STEP_BITS:0]         tm_ff, tm_in;
   logic [LCM_BITS-1:0]        l_ff, l_in, r_ff, r_in;
   logic [DIV_BITS-1:0]        x_ff, x_in;
   logic [VALUE_BITS-1:0]      hi_ff, hi_in;
   logic [VALUE_BITS:0]        olo_ff, olo_in, ohi_ff, ohi_in;
   logic [LCM_BITS:0]          ostep_ff, ostep_in;
   logic                       oempty_ff, oempty_in;
   logic                       valid_ff, valid_in;

   logic [DIV_BITS-1:0]        num, den, quo, rem;
   logic                       narrow, done;
   logic [VALUE_BITS-1:0]      maxlo, lim, absdiff;
   logic signed [2*STEP_BITS+2:0] tprod;
   logic signed [COEF_BITS-1:0] tsum;
   logic [DIV_BITS-1:0]        rr, ll, adj;

   // Shared iterative divider.
   sii_div u_div (
      .clock  (clock),
      .reset  (reset),
      .go     (cmd.go),
      .narrow (narrow),
      .num    (num),
      .den    (den),
      .quo    (quo),
      .rem    (rem),
      .done   (done)
   );

   // Bounds of the intersection window.
   assign maxlo   = (lo1_ff > lo2_ff) ? lo1_ff : lo2_ff;
   assign lim     = (hi1_ff < hi2_ff) ? hi1_ff : hi2_ff;
   assign absdiff = (lo2_ff >= lo1_ff) ? (lo2_ff - lo1_ff) : (lo1_ff - lo2_ff);

   // Divider operands for each pass.
   always_comb begin
      narrow = 1'b1;
      num    = '0;
      den    = DIV_BITS'(1);
      case (cmd.op)
         OP_EUC: begin
            num = DIV_BITS'(r0_ff);
            den = DIV_BITS'(r1_ff);
         end
         OP_S1G: begin
            num = DIV_BITS'(s1_ff);
            den = DIV_BITS'(r0_ff);
         end
         OP_S2G: begin
            num = DIV_BITS'(s2_ff);
            den = DIV_BITS'(r0_ff);
         end
         OP_DIFF: begin
            narrow = 1'b0;
            num    = DIV_BITS'(absdiff);
            den    = DIV_BITS'(s2_ff);
         end
         OP_DG: begin
            num = DIV_BITS'(d_ff);
            den = DIV_BITS'(r0_ff);
         end
         OP_KMOD: begin
            narrow = 1'b0;
            num    = DIV_BITS'(dq_ff * tm_ff);
            den    = DIV_BITS'(m_ff);
         end
         OP_X0: begin
            narrow = 1'b0;
            num    = DIV_BITS'(lo1_ff) + DIV_BITS'(s1_ff * k_ff);
            den    = DIV_BITS'(l_ff);
         end
         OP_T: begin
            narrow = 1'b0;
            num    = DIV_BITS'(maxlo);
            den    = DIV_BITS'(l_ff);
         end
         OP_HI: begin
            narrow = 1'b0;
            num    = DIV_BITS'(lim - x_ff[VALUE_BITS-1:0]);
            den    = DIV_BITS'(l_ff);
         end
         default: begin
            narrow = 1'b1;
         end
      endcase
   end

   // Coefficient update of the extended Euclid step and its reduction into range.
   assign tprod = $signed({1'b0, quo[STEP_BITS-1:0]}) * t1_ff;
   assign tsum  = t0_ff + $signed({2'b00, m_ff});
   assign rr    = DIV_BITS'(r_ff);
   assign ll    = DIV_BITS'(l_ff);
   assign adj   = (rr >= rem) ? (rr - rem) : (rr + ll - rem);

   // Working registers.
   always_comb begin
      lo1_in = lo1_ff;  lo2_in = lo2_ff;  hi1_in = hi1_ff;  hi2_in = hi2_ff;
      s1_in  = s1_ff;   s2_in  = s2_ff;   e_in   = e_ff;
      r0_in  = r0_ff;   r1_in  = r1_ff;   t0_in  = t0_ff;   t1_in  = t1_ff;
      a_in   = a_ff;    m_in   = m_ff;    d_in   = d_ff;    dq_in  = dq_ff;
      k_in   = k_ff;    tm_in  = tm_ff;   l_in   = l_ff;    r_in   = r_ff;
      x_in   = x_ff;    hi_in  = hi_ff;
      if (cmd.load) begin
         // A zero stride counts as a stride of one.
         lo1_in = first_lo;
         lo2_in = second_lo;
         hi1_in = first_hi;
         hi2_in = second_hi;
         s1_in  = (first_step == '0) ? STEP_BITS'(1) : first_step;
         s2_in  = (second_step == '0) ? STEP_BITS'(1) : second_step;
         e_in   = first_empty | second_empty;
         r0_in  = (second_step == '0) ? STEP_BITS'(1) : second_step;
         r1_in  = (first_step == '0) ? STEP_BITS'(1) : first_step;
         t0_in  = '0;
         t1_in  = COEF_BITS'(1);
         k_in   = '0;
      end else if (cmd.take) begin
         case (cmd.op)
            OP_EUC: begin
               r0_in = r1_ff;
               r1_in = rem[STEP_BITS-1:0];
               t0_in = t1_ff;
               t1_in = t0_ff - $signed(tprod[COEF_BITS-1:0]);
            end
            OP_S1G: begin
               a_in = quo[STEP_BITS-1:0];
            end
            OP_S2G: begin
               m_in = quo[STEP_BITS-1:0];
               l_in = a_ff * s2_ff;
            end
            OP_DIFF: begin
               if ((lo2_ff < lo1_ff) && (rem != '0)) begin
                  d_in = s2_ff - rem[STEP_BITS-1:0];
               end else begin
                  d_in = rem[STEP_BITS-1:0];
               end
            end
            OP_DG: begin
               dq_in = quo[STEP_BITS-1:0];
               tm_in = t0_ff[COEF_BITS-1] ? tsum[STEP_BITS:0] : t0_ff[STEP_BITS:0];
            end
            OP_KMOD: begin
               k_in = rem[STEP_BITS-1:0];
            end
            OP_X0: begin
               r_in = rem[LCM_BITS-1:0];
            end
            OP_T: begin
               // The unbounded code stands unless a bounded end is aligned later.
               x_in  = DIV_BITS'(maxlo) + adj;
               hi_in = '1;
            end
            OP_HI: begin
               hi_in = lim - rem[VALUE_BITS-1:0];
            end
            default: begin
               x_in = x_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      lo1_ff <= lo1_in;  lo2_ff <= lo2_in;  hi1_ff <= hi1_in;  hi2_ff <= hi2_in;
      s1_ff  <= s1_in;   s2_ff  <= s2_in;   e_ff   <= e_in;
      r0_ff  <= r0_in;   r1_ff  <= r1_in;   t0_ff  <= t0_in;   t1_ff  <= t1_in;
      a_ff   <= a_in;    m_ff   <= m_in;    d_ff   <= d_in;    dq_ff  <= dq_in;
      k_ff   <= k_in;    tm_ff  <= tm_in;   l_ff   <= l_in;    r_ff   <= r_in;
      x_ff   <= x_in;    hi_ff  <= hi_in;
   end

   // Output register, loaded when the controller delivers an item.
   always_comb begin
      olo_in    = olo_ff;
      ostep_in  = ostep_ff;
      ohi_in    = ohi_ff;
      oempty_in = oempty_ff;
      valid_in  = valid_ff & rsp_stall;
      if (cmd.emit) begin
         valid_in  = 1'b1;
         oempty_in = cmd.empty;
         olo_in    = cmd.empty ? '1 : {1'b0, x_ff[VALUE_BITS-1:0]};
         ostep_in  = cmd.empty ? '1 : {1'b0, l_ff};
         ohi_in    = cmd.empty ? '1 : {1'b0, hi_ff};
      end
   end

   always_ff @(posedge clock) begin
      olo_ff    <= olo_in;
      ostep_ff  <= ostep_in;
      ohi_ff    <= ohi_in;
      oempty_ff <= oempty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Status for the controller.
   assign stat.in_empty = e_ff;
   assign stat.div_done = done;
   assign stat.rem_zero = (rem == '0);
   assign stat.m_le1    = (m_ff <= STEP_BITS'(1));
   assign stat.x_gt_end = (x_ff > DIV_BITS'(lim));
   assign stat.end_inf  = (lim == '1);
   assign stat.rsp_busy = valid_ff & rsp_stall;

   assign rsp_valid = valid_ff;
   assign out_lo    = olo_ff;
   assign out_step  = ostep_ff;
   assign out_hi    = ohi_ff;
   assign out_empty = oempty_ff;

endmodule
`default_nettype wire

>>> rtl/sii_ctrl.sv
`default_nettype none
module sii_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sii_pkg::stat_type stat,
   output sii_pkg::cmd_type  cmd
);
   import sii_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_GO    = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0] state_ff, state_in;
   op_type     op_ff, op_in;
   logic       empty_ff, empty_in;

   // Sequencing of the divide passes for one item.
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      empty_in  = empty_ff;
      cmd       = '0;
      cmd.op    = op_ff;
      cmd.empty = empty_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            empty_in = stat.in_empty;
            op_in    = OP_EUC;
            state_in = stat.in_empty ? S_EMIT : S_GO;
         end
         S_GO: begin
            cmd.go   = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (stat.div_done) begin
               cmd.take = 1'b1;
               state_in = S_GO;
               case (op_ff)
                  OP_EUC: begin
                     if (stat.rem_zero) begin
                        op_in = OP_S1G;
                     end
                  end
                  OP_S1G:  op_in = OP_S2G;
                  OP_S2G:  op_in = OP_DIFF;
                  OP_DIFF: op_in = OP_DG;
                  OP_DG: begin
                     // Residues that the gcd does not divide leave no common member.
                     if (!stat.rem_zero) begin
                        empty_in = 1'b1;
                        state_in = S_EMIT;
                     end else if (stat.m_le1) begin
                        op_in = OP_X0;
                     end else begin
                        op_in = OP_KMOD;
                     end
                  end
                  OP_KMOD: op_in = OP_X0;
                  OP_X0:   op_in = OP_T;
                  OP_T:    state_in = S_CHECK;
                  OP_HI:   state_in = S_EMIT;
                  default: begin
                     empty_in = 1'b1;
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (stat.x_gt_end) begin
               empty_in = 1'b1;
               state_in = S_EMIT;
            end else if (stat.end_inf) begin
               state_in = S_EMIT;
            end else begin
               op_in    = OP_HI;
               state_in = S_GO;
            end
         end
         S_EMIT: begin
            if (!stat.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_EUC;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         empty_ff <= empty_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/strided_interval_intersect_core.sv
`default_nettype none
// Intersects two strided intervals and returns one item with the lowest common
// member, the lcm of the strides and the last common member, or an empty item
// with all fields at -1. Items are handled one at a time through a single
// shared divider that yields one quotient bit a cycle. The number of Euclid
// steps on the strides sets how many divide passes an item needs, and an item
// ends early when an input is empty or the residues do not meet. A finished
// item waits in the output register while the next item is already taken in.
module strided_interval_intersect_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sii_pkg::VALUE_BITS-1:0] req_first_lo,
   input  logic [sii_pkg::STEP_BITS-1:0]  req_first_step,
   input  logic [sii_pkg::VALUE_BITS-1:0] req_first_hi,
   input  logic                           req_first_empty,
   input  logic [sii_pkg::VALUE_BITS-1:0] req_second_lo,
   input  logic [sii_pkg::STEP_BITS-1:0]  req_second_step,
   input  logic [sii_pkg::VALUE_BITS-1:0] req_second_hi,
   input  logic                           req_second_empty,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sii_pkg::VALUE_BITS:0]   rsp_out_lo,
   output logic [sii_pkg::LCM_BITS:0]     rsp_out_step,
   output logic [sii_pkg::VALUE_BITS:0]   rsp_out_hi,
   output logic                           rsp_out_empty
);
   import sii_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   sii_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Arithmetic and result register.
   sii_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .first_lo     (req_first_lo),
      .first_step   (req_first_step),
      .first_hi     (req_first_hi),
      .first_empty  (req_first_empty),
      .second_lo    (req_second_lo),
      .second_step  (req_second_step),
      .second_hi    (req_second_hi),
      .second_empty (req_second_empty),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .out_lo       (rsp_out_lo),
      .out_step     (rsp_out_step),
      .out_hi       (rsp_out_hi),
      .out_empty    (rsp_out_empty)
   );

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sii_pkg::*;

   localparam int  HOLD_AT      = 40;
   localparam int  HOLD_CYCLES  = 3000;
   localparam int  CALM_TAIL    = 100;
   localparam int  DRAIN_CYCLES = 1500;
   localparam int  CYCLE_LIMIT  = 5000000;
   localparam longint unsigned UNBOUNDED = (64'd1 << VALUE_BITS) - 1;

   typedef struct {
      logic [VALUE_BITS-1:0] lo1;
      logic [STEP_BITS-1:0]  st1;
      logic [VALUE_BITS-1:0] hi1;
      logic                  e1;
      logic [VALUE_BITS-1:0] lo2;
      logic [STEP_BITS-1:0]  st2;
      logic [VALUE_BITS-1:0] hi2;
      logic                  e2;
   } pair_type;

   typedef struct {
      logic [VALUE_BITS:0] lo;
      logic [LCM_BITS:0]   step;
      logic [VALUE_BITS:0] hi;
      logic                empty;
   } meet_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [VALUE_BITS-1:0] req_first_lo = '0;
   logic [STEP_BITS-1:0]  req_first_step = '0;
   logic [VALUE_BITS-1:0] req_first_hi = '0;
   logic                  req_first_empty = 1'b0;
   logic [VALUE_BITS-1:0] req_second_lo = '0;
   logic [STEP_BITS-1:0]  req_second_step = '0;
   logic [VALUE_BITS-1:0] req_second_hi = '0;
   logic                  req_second_empty = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [VALUE_BITS:0] rsp_out_lo;
   logic [LCM_BITS:0]   rsp_out_step;
   logic [VALUE_BITS:0] rsp_out_hi;
   logic                rsp_out_empty;

   pair_type pending_pairs[$];
   meet_type meets_due[$];
   int    pairs_sent = 0;
   int    meets_seen = 0;
   int    empties_seen = 0;
   int    mismatches = 0;
   int    cycles = 0;
   int    send_gap = 0;
   int    recv_gap = 0;
   int    hold_left = 0;
   bit    hold_done = 1'b0;

   strided_interval_intersect_core i_dut (.*);

   always #1 clock = ~clock;

   // Euclid on the two strides.
   function automatic longint unsigned stride_gcd(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // Inverse of a modulo m by the extended Euclid recurrence.
   function automatic longint unsigned inverse_mod(longint unsigned a, longint unsigned m);
      longint r0, r1, c0, c1, q, t;
      r0 = m;
      r1 = a % m;
      c0 = 0;
      c1 = 1;
      while (r1 != 0) begin
         q = r0 / r1;
         t = r0 - q * r1;
         r0 = r1;
         r1 = t;
         t = c0 - q * c1;
         c0 = c1;
         c1 = t;
      end
      if (c0 < 0) c0 += m;
      return c0;
   endfunction

   // Expected intersection of one pair of strided intervals.
   function automatic meet_type predict_meet(pair_type p);
      meet_type res;
      longint unsigned s1, s2, g, m, lcm, d, k, r, maxlo, lim, t, x, h;
      res.lo = '1;
      res.step = '1;
      res.hi = '1;
      res.empty = 1'b1;
      s1 = (p.st1 == 0) ? 1 : p.st1;
      s2 = (p.st2 == 0) ? 1 : p.st2;
      if (p.e1 || p.e2) return res;
      g = stride_gcd(s1, s2);
      m = s2 / g;
      lcm = (s1 / g) * s2;
      if (p.lo2 >= p.lo1) d = (p.lo2 - p.lo1) % s2;
      else d = (s2 - ((p.lo1 - p.lo2) % s2)) % s2;
      if (d % g != 0) return res;
      k = (m <= 1) ? 0 : (((d / g) % m) * inverse_mod((s1 / g) % m, m)) % m;
      r = (p.lo1 + s1 * k) % lcm;
      maxlo = (p.lo1 > p.lo2) ? p.lo1 : p.lo2;
      lim = (p.hi1 < p.hi2) ? p.hi1 : p.hi2;
      t = maxlo % lcm;
      x = maxlo + ((r >= t) ? r - t : r + lcm - t);
      if (x > lim) return res;
      h = (lim == UNBOUNDED) ? UNBOUNDED : lim - ((lim - x) % lcm);
      res.lo = x[VALUE_BITS:0];
      res.step = lcm[LCM_BITS:0];
      res.hi = h[VALUE_BITS:0];
      res.empty = 1'b0;
      return res;
   endfunction

   function automatic pair_type make_pair(longint unsigned lo1, longint unsigned st1,
                                       longint unsigned hi1, bit e1, longint unsigned lo2,
                                       longint unsigned st2, longint unsigned hi2, bit e2);
      pair_type p;
      p.lo1 = lo1[VALUE_BITS-1:0]; p.st1 = st1[STEP_BITS-1:0];
      p.hi1 = hi1[VALUE_BITS-1:0]; p.e1 = e1;
      p.lo2 = lo2[VALUE_BITS-1:0]; p.st2 = st2[STEP_BITS-1:0];
      p.hi2 = hi2[VALUE_BITS-1:0]; p.e2 = e2;
      return p;
   endfunction

   // Random pair: mostly strides sharing a factor with residues that meet.
   function automatic pair_type random_pair();
      pair_type p;
      int unsigned kind, g, a, b, base, v;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         p = make_pair($urandom, $urandom, $urandom, $urandom_range(0, 1),
                       $urandom, $urandom, $urandom, $urandom_range(0, 1));
      end else begin
         g = $urandom_range(1, (kind < 5) ? 12 : 200);
         a = $urandom_range(1, 65535 / g);
         b = $urandom_range(1, 65535 / g);
         if (kind == 9) begin
            a = $urandom_range(1, 8);
            b = $urandom_range(1, 8);
         end
         base = (kind == 8) ? $urandom_range(32'h7ff0_0000, 32'h7fff_ffff)
                            : $urandom_range(0, 1 << $urandom_range(4, 30));
         p.lo1 = base[VALUE_BITS-1:0];
         v = base + g * $urandom_range(0, 500) + (($urandom_range(0, 5) == 0) ? 1 : 0);
         p.lo2 = v[VALUE_BITS-1:0];
         v = g * a;
         p.st1 = ($urandom_range(0, 40) == 0) ? '0 : v[STEP_BITS-1:0];
         v = g * b;
         p.st2 = ($urandom_range(0, 40) == 0) ? '0 : v[STEP_BITS-1:0];
         v = p.lo1 + $urandom_range(0, 1 << $urandom_range(4, 30));
         p.hi1 = ($urandom_range(0, 3) == 0) ? '1 : v[VALUE_BITS-1:0];
         v = p.lo2 + $urandom_range(0, 1 << $urandom_range(4, 30));
         p.hi2 = ($urandom_range(0, 3) == 0) ? '1 : v[VALUE_BITS-1:0];
         if (p.hi1 < p.lo1) p.hi1 = '1;
         if (p.hi2 < p.lo2) p.hi2 = '1;
         p.e1 = ($urandom_range(0, 15) == 0);
         p.e2 = ($urandom_range(0, 15) == 0);
      end
      return p;
   endfunction

   // Sender: offers the next pending item, with random bursts of idle cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            meets_due.push_back(predict_meet(make_pair(req_first_lo, req_first_step,
               req_first_hi, req_first_empty, req_second_lo, req_second_step,
               req_second_hi, req_second_empty)));
            pairs_sent++;
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_pairs.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            send_gap <= $urandom_range(0, 5);
            req_valid <= 1'b0;
         end else if (pending_pairs.size() > 0) begin
            req_first_lo <= pending_pairs[0].lo1;
            req_first_step <= pending_pairs[0].st1;
            req_first_hi <= pending_pairs[0].hi1;
            req_first_empty <= pending_pairs[0].e1;
            req_second_lo <= pending_pairs[0].lo2;
            req_second_step <= pending_pairs[0].st2;
            req_second_hi <= pending_pairs[0].hi2;
            req_second_empty <= pending_pairs[0].e2;
            void'(pending_pairs.pop_front());
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall: one long hold early on, and random bursts until the calm tail.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && pairs_sent >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_stall <= 1'b1;
      end else if (pending_pairs.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
         recv_gap <= $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Checker: each accepted result against the oldest expectation.
   always @(posedge clock) begin
      meet_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         meets_seen++;
         if (rsp_out_empty) empties_seen++;
         if (meets_due.size() == 0) begin
            $display("%0t: result with nothing expected (lo %0d)", $time, rsp_out_lo);
            mismatches++;
         end else begin
            want = meets_due.pop_front();
            if (rsp_out_lo !== want.lo) begin
               $display("%0t: lo expected %h got %h", $time, want.lo, rsp_out_lo);
               mismatches++;
            end
            if (rsp_out_step !== want.step) begin
               $display("%0t: step expected %h got %h", $time, want.step, rsp_out_step);
               mismatches++;
            end
            if (rsp_out_hi !== want.hi) begin
               $display("%0t: hi expected %h got %h", $time, want.hi, rsp_out_hi);
               mismatches++;
            end
            if (rsp_out_empty !== want.empty) begin
               $display("%0t: empty expected %b got %b", $time, want.empty, rsp_out_empty);
               mismatches++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      // Directed items: extremes, empties, zero strides, disjoint residues, unbounded.
      pending_pairs.push_back(make_pair(0, 1, 0, 0, 0, 1, 0, 0));
      pending_pairs.push_back(make_pair(UNBOUNDED, 65535, UNBOUNDED, 1,
                                        UNBOUNDED, 65535, UNBOUNDED, 1));
      pending_pairs.push_back(make_pair(0, 3, 100, 1, 0, 3, 100, 0));
      pending_pairs.push_back(make_pair(0, 3, 100, 0, 0, 3, 100, 1));
      pending_pairs.push_back(make_pair(5, 0, 50, 0, 7, 0, 40, 0));
      pending_pairs.push_back(make_pair(0, 2, 100, 0, 1, 4, 101, 0));
      pending_pairs.push_back(make_pair(0, 4, 8, 0, 2, 6, 8, 0));
      pending_pairs.push_back(make_pair(0, 65535, UNBOUNDED, 0, 0, 65534, UNBOUNDED, 0));
      pending_pairs.push_back(make_pair(3, 65535, UNBOUNDED, 0, 11, 65534, UNBOUNDED, 0));
      pending_pairs.push_back(make_pair(0, 65521, UNBOUNDED, 0, 1, 65519, 2000000000, 0));
      pending_pairs.push_back(make_pair(10, 3, UNBOUNDED, 0, 11, 5, UNBOUNDED, 0));
      pending_pairs.push_back(make_pair(100, 7, 10, 0, 0, 1, 1000, 0));
      pending_pairs.push_back(make_pair(0, 6, 1000, 0, 999, 10, 2000, 0));
      pending_pairs.push_back(make_pair(UNBOUNDED, 1, UNBOUNDED, 0, 0, 1, UNBOUNDED, 0));
      pending_pairs.push_back(make_pair(UNBOUNDED - 1, 2, UNBOUNDED, 0, 1, 3, UNBOUNDED, 0));
      pending_pairs.push_back(make_pair(0, 12, 1000, 0, 4, 18, 1001, 0));
      pending_pairs.push_back(make_pair(17, 0, 17, 0, 17, 65535, 17, 0));
      pending_pairs.push_back(make_pair(2, 5, 47, 0, 0, 1, UNBOUNDED, 0));
      pending_pairs.push_back(make_pair(0, 32768, UNBOUNDED, 0, 0, 16384, 1 << 30, 0));
      pending_pairs.push_back(make_pair(1, 2, 3, 0, 2, 2, 3, 0));
      repeat (800) pending_pairs.push_back(random_pair());

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (pending_pairs.size() == 0 && !req_valid && meets_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d interval pairs; %0d intersections checked, %0d of them empty.",
               pairs_sent, meets_seen, empties_seen);
      $display("Run included a long output hold-off and random idling on both sides.");
      if (mismatches == 0 && meets_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> strided_interval_intersect_core.f
rtl/sii_pkg.sv
rtl/sii_div.sv
rtl/sii_datapath.sv
rtl/sii_ctrl.sv
rtl/strided_interval_intersect_core.sv
test/tb_top.sv
